// ===== design/utt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utt_pkg
// Types, constants and byte classification shared by the transcoder modules.
// ----------------------------------------------------------------------------
package utt_pkg;

  localparam logic [15:0] REPL_UNIT     = 16'h003F;
  localparam logic [15:0] SUR_HIGH      = 16'hD800;
  localparam logic [15:0] SUR_LOW       = 16'hDC00;
  localparam logic [20:0] SUPPLEMENTARY = 21'h10000;
  localparam int          MaxUnits      = 4;

  typedef enum logic [2:0] {
    CLS_CONT,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } byte_class_t;

  typedef struct packed {
    logic [15:0] code;
    logic        repl;
  } unit_t;

  // All units that one accepted byte gives, in output order.
  typedef struct packed {
    unit_t [MaxUnits-1:0] units;
    logic  [2:0]          count;
    logic                 last;
  } entry_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t cls;
    if (!b[7]) begin
      cls = CLS_ASCII;
    end else if (!b[6]) begin
      cls = CLS_CONT;
    end else if (!b[5]) begin
      cls = CLS_LEAD2;
    end else if (!b[4]) begin
      cls = CLS_LEAD3;
    end else if (!b[3]) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_INVALID;
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

// ===== design/utt_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utt_if
// Valid/ready channels for UTF-8 bytes in and UTF-16 code units out.
// ----------------------------------------------------------------------------
interface utt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface utt_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        is_replacement;
  logic        unit_last;

  modport source (output valid, output code_unit, output is_replacement,
                  output unit_last, input ready);
  modport sink   (input valid, input code_unit, input is_replacement,
                  input unit_last, output ready);
endinterface
`default_nettype wire

// ===== design/utt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utt_front
// Classifies each byte, tracks the open sequence and builds the unit list.
// ----------------------------------------------------------------------------
module utt_front
  import utt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  utt_byte_if.sink    bytes,
  output logic        push_valid,
  output entry_t      push_entry,
  input  wire logic   push_ready
);

  logic [7:0]  held_bytes [3];
  logic [1:0]  held_count, held_count_next;
  logic [2:0]  sequence_length, sequence_length_next;

  byte_class_t cls;
  logic        accept;
  logic        extend;
  logic        complete;
  logic        store_lead;
  logic        store_cont;
  logic [1:0]  pre_cnt;
  logic [1:0]  main_cnt;
  logic [1:0]  post_cnt;
  logic [1:0]  held_after;
  logic [2:0]  seq_after;
  unit_t       main_u [2];
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic [2:0]  sel;
  entry_t      entry;

  assign accept      = bytes.valid && push_ready;
  assign bytes.ready = push_ready;
  assign cls         = classify(bytes.in_byte);

  // Code point of the sequence that this continuation byte completes.
  always_comb begin
    case (sequence_length)
      3'd2:    cp = {10'b0, held_bytes[0][4:0], bytes.in_byte[5:0]};
      3'd3:    cp = {5'b0, held_bytes[0][3:0], held_bytes[1][5:0],
                     bytes.in_byte[5:0]};
      default: cp = {held_bytes[0][2:0], held_bytes[1][5:0], held_bytes[2][5:0],
                     bytes.in_byte[5:0]};
    endcase
    cp_off = cp - SUPPLEMENTARY;
  end

  always_comb begin
    extend     = (held_count != 2'd0) && (cls == CLS_CONT);
    complete   = extend && (({1'b0, held_count} + 3'd1) >= sequence_length);
    store_cont = extend && !complete;
    store_lead = 1'b0;
    pre_cnt    = 2'd0;
    main_cnt   = 2'd0;
    held_after = held_count;
    seq_after  = sequence_length;
    main_u[0]  = '{code: REPL_UNIT, repl: 1'b1};
    main_u[1]  = '{code: SUR_LOW + {6'b0, cp_off[9:0]}, repl: 1'b0};

    if (complete) begin
      held_after = 2'd0;
      seq_after  = 3'd0;
      if (cp[20:16] != 5'd0) begin
        main_cnt  = 2'd2;
        main_u[0] = '{code: SUR_HIGH + {5'b0, cp_off[20:10]}, repl: 1'b0};
      end else begin
        main_cnt  = 2'd1;
        main_u[0] = '{code: cp[15:0], repl: 1'b0};
      end
    end else if (store_cont) begin
      held_after = held_count + 2'd1;
    end else begin
      pre_cnt    = held_count;
      held_after = 2'd0;
      seq_after  = 3'd0;
      unique case (cls)
        CLS_ASCII: begin
          main_cnt  = 2'd1;
          main_u[0] = '{code: {8'b0, bytes.in_byte}, repl: 1'b0};
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          store_lead = 1'b1;
          held_after = 2'd1;
          seq_after  = (cls == CLS_LEAD2) ? 3'd2 : (cls == CLS_LEAD3) ? 3'd3 : 3'd4;
        end
        default: begin
          main_cnt = 2'd1;
        end
      endcase
    end

    // End of string flushes whatever is still held.
    if (bytes.in_last) begin
      post_cnt             = held_after;
      held_count_next      = 2'd0;
      sequence_length_next = 3'd0;
    end else begin
      post_cnt             = 2'd0;
      held_count_next      = held_after;
      sequence_length_next = seq_after;
    end

    for (int k = 0; k < MaxUnits; k++) begin
      sel = 3'(k) - {1'b0, pre_cnt};
      if (3'(k) < {1'b0, pre_cnt}) begin
        entry.units[k] = '{code: REPL_UNIT, repl: 1'b1};
      end else if (3'(k) < ({1'b0, pre_cnt} + {1'b0, main_cnt})) begin
        entry.units[k] = main_u[sel[0]];
      end else begin
        entry.units[k] = '{code: REPL_UNIT, repl: 1'b1};
      end
    end
    entry.count = {1'b0, pre_cnt} + {1'b0, main_cnt} + {1'b0, post_cnt};
    entry.last  = bytes.in_last;
  end

  assign push_valid = accept && (entry.count != 3'd0);
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      sequence_length <= 3'd0;
    end else if (accept) begin
      held_count      <= held_count_next;
      sequence_length <= sequence_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_lead) begin
      held_bytes[0] <= bytes.in_byte;
    end
    if (accept && store_cont) begin
      held_bytes[held_count] <= bytes.in_byte;
    end
  end

endmodule
`default_nettype wire

// ===== design/utt_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utt_queue
// Two-entry queue of unit lists between the front and the back.
// ----------------------------------------------------------------------------
module utt_queue
  import utt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push_valid,
  input  wire entry_t push_entry,
  output logic        push_ready,
  output logic        pop_valid,
  output entry_t      pop_entry,
  input  wire logic   pop
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== design/utt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utt_back
// Sends the units of the head queue entry one per request.
// ----------------------------------------------------------------------------
module utt_back
  import utt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   pop_valid,
  input  wire entry_t pop_entry,
  output logic        pop,
  utt_unit_if.source  units
);

  logic [1:0] idx, idx_next;
  logic       at_end;
  logic       taken;
  unit_t      cur;

  assign cur    = pop_entry.units[idx];
  assign at_end = ({1'b0, idx} == (pop_entry.count - 3'd1));
  assign taken  = units.valid && units.ready;

  assign units.valid          = pop_valid;
  assign units.code_unit      = cur.code;
  assign units.is_replacement = cur.repl;
  assign units.unit_last      = pop_entry.last && at_end;
  assign pop                  = taken && at_end;

  always_comb begin
    idx_next = idx;
    if (taken) begin
      idx_next = at_end ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else begin
      idx <= idx_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/utf8_to_utf16_transcoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// Streams UTF-8 bytes in and UTF-16 code units out, one unit per request.
// ----------------------------------------------------------------------------
// Path: a byte's units are registered in the queue before the back offers them.
// Throughput: one byte per cycle while each byte gives at most one unit and the
//   output is ready; a byte of k units (1 to 4) holds the port for k requests.
// Reset: synchronous, clears the held count, the sequence length, the queue
//   pointers and the unit index; the held byte registers are left as they are.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top
  import utt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  utt_byte_if.sink   bytes,
  utt_unit_if.source units
);

  // The front decodes a byte as soon as it arrives and turns it into a
  // complete list of the units it causes, so the state of the open sequence
  // is up to date before the next byte.
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;

  // The queue decouples decoding from delivery. Its full flag alone gates
  // input ready, so there is no path from the output ready to the input.
  logic   pop_valid;
  logic   pop;
  entry_t pop_entry;

  utt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  utt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop)
  );

  // The back walks the head entry one unit per accepted request and marks
  // the final unit of a last-flagged byte.
  utt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .units     (units)
  );

endmodule
`default_nettype wire

// ===== test/utf8_to_utf16_transcoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top_tb
// Feeds UTF-8 byte requests into the transcoder and checks every UTF-16 code
// unit that comes out against a cycle-free decoder model kept in the bench.
// A directed set of edge-case bytes runs first. Random strings, broken
// sequences and noise bytes follow, in four phases of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top_tb;
  import utt_pkg::*;

  // One byte request as it is queued for the driver.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } byte_req_t;

  // One code unit that the decoder model says must come out.
  typedef struct packed {
    logic [15:0] code;
    logic        repl;
    logic        last;
  } unit_exp_t;

  logic clk;
  logic rst;

  utt_byte_if byte_ch ();
  utt_unit_if unit_ch ();

  utf8_to_utf16_transcoder_top dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_ch),
    .units (unit_ch)
  );

  // Byte requests waiting for the driver, and the code units that the
  // accepted bytes have produced in the model but that have not come out yet.
  byte_req_t pending_bytes[$];
  unit_exp_t expected_units[$];

  // Decoder model state: the lead and continuation bytes of the sequence in
  // progress, how many of them are held, and the length the lead announced.
  logic [7:0] held[3];
  logic [1:0] held_cnt;
  logic [2:0] seq_len;

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int queued_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A hung handshake or a lost unit ends up here.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  // The top five bits of a byte decide what it is.
  function automatic byte_class_t class_of(input logic [7:0] b);
    byte_class_t cls;
    casez (b[7:3])
      5'b0????: cls = CLS_ASCII;
      5'b10???: cls = CLS_CONT;
      5'b110??: cls = CLS_LEAD2;
      5'b1110?: cls = CLS_LEAD3;
      5'b11110: cls = CLS_LEAD4;
      default:  cls = CLS_INVALID;
    endcase
    return cls;
  endfunction

  function automatic void push_unit(input logic [15:0] code, input logic repl);
    unit_exp_t u;
    u.code = code;
    u.repl = repl;
    u.last = 1'b0;
    expected_units.push_back(u);
  endfunction

  // Every byte still held turns into its own replacement unit.
  function automatic void flush_held();
    for (int k = 0; k < int'(held_cnt); k++) begin
      push_unit(REPL_UNIT, 1'b1);
    end
    held_cnt = 2'd0;
    seq_len  = 3'd0;
  endfunction

  // Code points from 0x10000 up are split into a high and a low surrogate.
  function automatic void emit_code_point(input logic [20:0] cp);
    logic [20:0] offset;
    if (cp < SUPPLEMENTARY) begin
      push_unit(cp[15:0], 1'b0);
    end else begin
      offset = cp - SUPPLEMENTARY;
      push_unit(SUR_HIGH + {5'b0, offset[20:10]}, 1'b0);
      push_unit(SUR_LOW + {6'b0, offset[9:0]}, 1'b0);
    end
  endfunction

  // Runs one accepted byte through the model and queues the units it gives.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    byte_class_t cls;
    int          first_idx;
    logic [20:0] cp;
    unit_exp_t   tail;
    cls       = class_of(b);
    first_idx = expected_units.size();
    if (held_cnt != 2'd0 && cls == CLS_CONT) begin
      if (int'(held_cnt) + 1 >= int'(seq_len)) begin
        // The continuation completes the sequence.
        case (seq_len)
          3'd2: cp = {10'b0, held[0][4:0], b[5:0]};
          3'd3: cp = {5'b0, held[0][3:0], held[1][5:0], b[5:0]};
          default: cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
        endcase
        emit_code_point(cp);
        held_cnt = 2'd0;
        seq_len  = 3'd0;
      end else begin
        held[held_cnt] = b;
        held_cnt       = held_cnt + 2'd1;
      end
    end else begin
      // A sequence broken by a non-continuation byte is flushed first, and
      // the new byte is then decoded as if nothing had been held.
      if (held_cnt != 2'd0) begin
        flush_held();
      end
      case (cls)
        CLS_ASCII: push_unit({8'h00, b}, 1'b0);
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          held[0]  = b;
          held_cnt = 2'd1;
          if (cls == CLS_LEAD2) begin
            seq_len = 3'd2;
          end else if (cls == CLS_LEAD3) begin
            seq_len = 3'd3;
          end else begin
            seq_len = 3'd4;
          end
        end
        // Lone continuation bytes and F8-FF each give one replacement.
        default: push_unit(REPL_UNIT, 1'b1);
      endcase
    end
    // The end of a string flushes what is held and marks the final unit.
    if (last) begin
      flush_held();
      if (expected_units.size() > first_idx) begin
        tail      = expected_units.pop_back();
        tail.last = 1'b1;
        expected_units.push_back(tail);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers the queued byte requests, idling at the phase's rate. The
  // model sees a byte at the edge where the request is accepted, which keeps
  // the expected units in the same order the block works in.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_req_t req;
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.in_byte, byte_ch.in_last);
      end
      // A request still waiting for ready is held as it is.
      if (!byte_ch.valid || byte_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req             = pending_bytes.pop_front();
          byte_ch.valid   <= 1'b1;
          byte_ch.in_byte <= req.b;
          byte_ch.in_last <= req.last;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes code units with a random ready and compares each one with
  // the oldest unit the model has queued.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    unit_exp_t want;
    if (rst) begin
      unit_ch.ready <= 1'b0;
    end else begin
      if (unit_ch.valid && unit_ch.ready) begin
        if (expected_units.size() == 0) begin
          $error("unexpected unit: code_unit %h, is_replacement %b, unit_last %b",
                 unit_ch.code_unit, unit_ch.is_replacement, unit_ch.unit_last);
          fail_count++;
        end else begin
          want = expected_units.pop_front();
          if (unit_ch.code_unit !== want.code) begin
            $error("code_unit mismatch: expected %h, actual %h", want.code,
                   unit_ch.code_unit);
            fail_count++;
          end
          if (unit_ch.is_replacement !== want.repl) begin
            $error("is_replacement mismatch: expected %b, actual %b", want.repl,
                   unit_ch.is_replacement);
            fail_count++;
          end
          if (unit_ch.unit_last !== want.last) begin
            $error("unit_last mismatch: expected %b, actual %b", want.last,
                   unit_ch.unit_last);
            fail_count++;
          end
        end
      end
      unit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_req(input logic [7:0] b, input logic last);
    byte_req_t req;
    req.b    = b;
    req.last = last;
    pending_bytes.push_back(req);
    queued_count++;
  endtask

  function automatic logic [7:0] rand_cont();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  // A lead byte with random payload bits for a sequence of the given length.
  function automatic logic [7:0] rand_lead(input int len);
    logic [7:0] b;
    case (len)
      2: b = {3'b110, 5'($urandom_range(31))};
      3: b = {4'b1110, 4'($urandom_range(15))};
      default: b = {5'b11110, 3'($urandom_range(7))};
    endcase
    return b;
  endfunction

  // A well-formed string of one to six characters with random content. Most
  // strings end with the last flag; the rest run on into the next one.
  task automatic add_string();
    int   chars;
    int   len;
    logic end_flag;
    logic fin;
    chars    = $urandom_range(1, 6);
    end_flag = ($urandom_range(99) < 85);
    for (int i = 0; i < chars; i++) begin
      fin = end_flag && (i == chars - 1);
      len = $urandom_range(1, 4);
      if (len == 1 || $urandom_range(9) < 3) begin
        push_req({1'b0, 7'($urandom_range(127))}, fin);
      end else begin
        push_req(rand_lead(len), 1'b0);
        for (int k = 1; k < len; k++) begin
          push_req(rand_cont(), fin && (k == len - 1));
        end
      end
    end
  endtask

  // A lead followed by too few continuations, then cut either by the end of
  // the string or by a byte that is not a continuation.
  task automatic add_broken();
    int         need;
    int         have;
    logic       cut_by_end;
    logic [7:0] term;
    need = $urandom_range(2, 4);
    have = $urandom_range(0, need - 2);
    cut_by_end = (have > 0) && ($urandom_range(3) == 0);
    push_req(rand_lead(need), 1'b0);
    for (int k = 0; k < have; k++) begin
      push_req(rand_cont(), cut_by_end && (k == have - 1));
    end
    if (!cut_by_end) begin
      do begin
        term = 8'($urandom_range(255));
      end while (term[7:6] == 2'b10);
      push_req(term, 1'($urandom_range(1)));
    end
  endtask

  // Waits until every request has been taken and every unit has come out.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_ch.valid || expected_units.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int send_tab[4];
    int recv_tab[4];
    int pick;
    send_tab = '{0, 76, 0, 35};
    recv_tab = '{0, 0, 76, 35};

    // Every input of the block is known from time zero on.
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = 8'h00;
    byte_ch.in_last = 1'b0;
    unit_ch.ready   = 1'b0;
    held_cnt        = 2'd0;
    seq_len         = 3'd0;
    fail_count      = 0;
    queued_count    = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_tab[p];
      recv_stall_pct = recv_tab[p];
      if (p == 0) begin
        // ASCII extremes and a literal question mark, which is not a
        // replacement.
        push_req(8'h00, 1'b0);
        push_req(8'h7F, 1'b0);
        push_req(8'h3F, 1'b0);
        // Lone continuation bytes and invalid leads.
        push_req(8'h80, 1'b0);
        push_req(8'hBF, 1'b0);
        push_req(8'hF8, 1'b0);
        push_req(8'hFF, 1'b0);
        // Overlong two-byte form, which decodes without complaint.
        push_req(8'hC0, 1'b0);
        push_req(8'h80, 1'b0);
        // Top of the basic plane.
        push_req(8'hEF, 1'b0);
        push_req(8'hBF, 1'b0);
        push_req(8'hBF, 1'b0);
        // First supplementary code point, one surrogate pair.
        push_req(8'hF0, 1'b0);
        push_req(8'h90, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'h80, 1'b0);
        // Largest value a four-byte lead can carry, far above 0x10FFFF.
        push_req(8'hF7, 1'b0);
        push_req(8'hBF, 1'b0);
        push_req(8'hBF, 1'b0);
        push_req(8'hBF, 1'b0);
        // A three-byte sequence broken by an ASCII byte.
        push_req(8'hE2, 1'b0);
        push_req(8'h82, 1'b0);
        push_req(8'h41, 1'b0);
        // Sequences cut short by the end of the string.
        push_req(8'hF0, 1'b0);
        push_req(8'h9F, 1'b1);
        push_req(8'hC3, 1'b1);
        queued_count = 0;
      end
      // Mostly well-formed strings, with broken sequences and raw noise.
      while (queued_count < 108) begin
        pick = $urandom_range(9);
        if (pick < 7) begin
          add_string();
        end else if (pick < 9) begin
          add_broken();
        end else begin
          push_req(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
      end
      queued_count = 0;
      // The sender holds off here until every expected unit has come out.
      wait_drained();
    end

    // Waiting on after the drain catches any unit the block emits beyond the model.
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
